// ===== hdl/assert_macros.svh =====
// Assertion macros used by the checker file of this block.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property whose consequent must hold in the same cycle as its antecedent.
`define ASSERT_SAME(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");

// Property whose consequent must hold in the cycle after its antecedent.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

// ===== hdl/hmcp_pkg.sv =====
// Package with the types, codes and character helpers of the hex monitor parser.
package hmcp_pkg;

    // Width of the accumulator, pointer and store addresses.
    localparam int ADDR_W = 12;
    localparam int BYTE_W = 8;
    localparam int DIGIT_W = 4;

    // Quotient width of an address divided by the smallest store depth of 16.
    localparam int QUOT_W = ADDR_W - 4;

    // Character codes.
    localparam logic [7:0] CH_AT       = 8'h40;
    localparam logic [7:0] CH_LIST     = 8'h4C;
    localparam logic [7:0] CH_EXEC     = 8'h58;
    localparam logic [7:0] CH_NEWLINE  = 8'h0A;
    localparam logic [7:0] CH_SPACE    = 8'h20;
    localparam logic [7:0] CH_ZERO     = 8'h30;
    localparam logic [7:0] CH_NINE     = 8'h39;
    localparam logic [7:0] CH_LOWER_A  = 8'h61;
    localparam logic [7:0] CH_LOWER_F  = 8'h66;
    localparam logic [7:0] CH_UPPER_A  = 8'h41;
    localparam logic [7:0] CH_UPPER_F  = 8'h46;
    localparam logic [7:0] LETTER_BASE = 8'd10;

    // Result kinds.
    typedef enum logic [2:0] {
        KIND_EXEC   = 3'd0,
        KIND_LIST   = 3'd1,
        KIND_ERROR  = 3'd2,
        KIND_HALTED = 3'd3,
        KIND_READ   = 3'd4
    } t_kind;

    // Parser states.
    typedef enum logic [2:0] {
        PS_INITIAL = 3'd0,
        PS_INSERT  = 3'd1,
        PS_READ_OP = 3'd2,
        PS_ADDRESS = 3'd3,
        PS_HALTED  = 3'd4
    } t_pstate;

    // Character classes.
    typedef enum logic [2:0] {
        CL_AT      = 3'd0,
        CL_L       = 3'd1,
        CL_X       = 3'd2,
        CL_DIGIT   = 3'd3,
        CL_SPACE   = 3'd4,
        CL_NEWLINE = 3'd5,
        CL_UNKNOWN = 3'd6
    } t_class;

    // Pending commands.
    typedef enum logic [1:0] {
        CMD_NONE    = 2'd0,
        CMD_POINTER = 2'd1,
        CMD_LIST    = 2'd2,
        CMD_EXECUTE = 2'd3
    } t_cmd;

    // Store write request issued when a word is accepted.
    typedef struct packed {
        logic              valid;
        logic [ADDR_W-1:0] addr;
        logic [BYTE_W-1:0] data;
    } t_wr_req;

    // Store read request issued when a word is accepted.
    typedef struct packed {
        logic              valid;
        logic [ADDR_W-1:0] addr;
    } t_rd_req;

    // Result descriptor of one accepted word.
    typedef struct packed {
        logic              valid;
        t_kind             kind;
        logic [ADDR_W-1:0] start;
        logic [ADDR_W-1:0] target;
    } t_desc;

    // Flow control from the result stage.
    typedef struct packed {
        logic s1_ready;
        logic s1_adv;
    } t_flow;

    // Classify one character code.
    function automatic t_class f_classify(input logic [7:0] c);
        t_class cl;
        if (c == CH_AT) cl = CL_AT;
        else if (c == CH_LIST) cl = CL_L;
        else if (c == CH_EXEC) cl = CL_X;
        else if (c == CH_NEWLINE) cl = CL_NEWLINE;
        else if (c == CH_SPACE) cl = CL_SPACE;
        else if (c >= CH_ZERO && c <= CH_NINE) cl = CL_DIGIT;
        else if (c >= CH_LOWER_A && c <= CH_LOWER_F) cl = CL_DIGIT;
        else if (c >= CH_UPPER_A && c <= CH_UPPER_F) cl = CL_DIGIT;
        else cl = CL_UNKNOWN;
        return cl;
    endfunction

    // Value of a hex digit character; only meaningful for the digit class.
    function automatic logic [DIGIT_W-1:0] f_digit(input logic [7:0] c);
        logic [7:0] v;
        if (c >= CH_LOWER_A && c <= CH_LOWER_F) v = c - CH_LOWER_A + LETTER_BASE;
        else if (c >= CH_UPPER_A && c <= CH_UPPER_F) v = c - CH_UPPER_A + LETTER_BASE;
        else v = c - CH_ZERO;
        return v[DIGIT_W-1:0];
    endfunction

endpackage

// ===== hdl/hex_monitor_command_parser_unit.sv =====
// Top level of the hex monitor command parser.
//
// Input channel (i_valid / o_stall) carries one word: either a character event
// (i_op = 0, i_char_code) or a store read (i_op = 1, i_read_addr). Output channel
// (o_valid / i_stall) carries result words: execute, list range, error, halted
// and read data; o_last marks the final word caused by one input word.
// An error gives two words, error then halted; later characters are dropped.
// Throughput is one input word per cycle while o_stall is low. A read word passes
// the result stage and the output register, its byte coming from the store's
// registered read port; other results take the same path. The halted word comes
// straight after its error word; while it is pending the result stage holds, so a
// read word waiting there keeps o_stall high until the halted word is loaded.
// After reset the block clears the store one entry a cycle, MEM_DEPTH entries
// in all, and holds o_stall high until that pass ends.
// When the receiver stalls, the output word holds and one more input word is
// taken into the result stage before o_stall rises.
module hex_monitor_command_parser_unit
    import hmcp_pkg::*;
#(
    parameter int MEM_DEPTH = 4096
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    output logic              o_stall,
    input  logic              i_op,
    input  logic [7:0]        i_char_code,
    input  logic [ADDR_W-1:0] i_read_addr,
    output logic              o_valid,
    input  logic              i_stall,
    output logic [2:0]        o_kind,
    output logic [ADDR_W-1:0] o_range_start,
    output logic [ADDR_W-1:0] o_target_addr,
    output logic [BYTE_W-1:0] o_read_byte,
    output logic              o_last
);

    t_wr_req           wr;
    t_rd_req           rd;
    t_desc             desc;
    t_flow             flow;
    logic              busy;
    logic              accept;
    logic [BYTE_W-1:0] rdata;

    // Input handshake.
    assign o_stall = busy || !flow.s1_ready;
    assign accept  = i_valid && !o_stall;

    hmcp_parser u_parser (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_accept    (accept),
        .i_op        (i_op),
        .i_char_code (i_char_code),
        .i_read_addr (i_read_addr),
        .o_wr        (wr),
        .o_rd        (rd),
        .o_desc      (desc)
    );

    hmcp_store #(
        .MEM_DEPTH (MEM_DEPTH)
    ) u_store (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_wr     (wr),
        .i_rd     (rd),
        .i_rd_adv (flow.s1_adv),
        .o_busy   (busy),
        .o_rdata  (rdata)
    );

    hmcp_out u_out (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_desc        (desc),
        .i_rdata       (rdata),
        .i_stall       (i_stall),
        .o_flow        (flow),
        .o_valid       (o_valid),
        .o_kind        (o_kind),
        .o_range_start (o_range_start),
        .o_target_addr (o_target_addr),
        .o_read_byte   (o_read_byte),
        .o_last        (o_last)
    );

endmodule

// ===== hdl/hmcp_parser.sv =====
// Character parser: classifier, state machine, accumulator and pointer registers.
module hmcp_parser
    import hmcp_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_accept,
    input  logic              i_op,
    input  logic [7:0]        i_char_code,
    input  logic [ADDR_W-1:0] i_read_addr,
    output t_wr_req           o_wr,
    output t_rd_req           o_rd,
    output t_desc             o_desc
);

    t_pstate           r_state, n_state;
    logic [ADDR_W-1:0] r_acc, n_acc;
    logic [ADDR_W-1:0] r_wp, n_wp;
    logic [ADDR_W-1:0] r_farg, n_farg;
    t_cmd              r_pend, n_pend;

    t_class             cls;
    logic [DIGIT_W-1:0] dig;
    logic [ADDR_W-1:0]  acc_sh;
    logic               char_evt;
    logic               legal;
    logic               bad;

    // Character decode and shifted accumulator.
    assign cls      = f_classify(i_char_code);
    assign dig      = f_digit(i_char_code);
    assign acc_sh   = {r_acc[ADDR_W-DIGIT_W-1:0], dig};
    assign char_evt = i_accept && !i_op && (r_state != PS_HALTED);

    // Which classes each state takes without error.
    always_comb begin
        case (r_state)
            PS_INITIAL: legal = (cls != CL_UNKNOWN);
            PS_INSERT,
            PS_ADDRESS: legal = (cls == CL_DIGIT) || (cls == CL_SPACE) || (cls == CL_NEWLINE);
            PS_READ_OP: legal = (cls == CL_DIGIT) || (cls == CL_SPACE);
            default:    legal = 1'b0;
        endcase
    end

    assign bad = char_evt && !legal;

    // Next state.
    always_comb begin
        n_state = r_state;
        if (bad) begin
            n_state = PS_HALTED;
        end else if (char_evt) begin
            case (r_state)
                PS_INITIAL: begin
                    case (cls)
                        CL_AT:    n_state = PS_READ_OP;
                        CL_L,
                        CL_X:     n_state = PS_ADDRESS;
                        CL_DIGIT: n_state = PS_INSERT;
                        default:  n_state = PS_INITIAL;
                    endcase
                end
                PS_INSERT: begin
                    if (cls == CL_NEWLINE) n_state = PS_INITIAL;
                end
                PS_READ_OP: n_state = PS_ADDRESS;
                PS_ADDRESS: begin
                    if (cls == CL_NEWLINE) n_state = PS_INITIAL;
                end
                default: n_state = r_state;
            endcase
        end
    end

    // Datapath updates, store requests and result descriptor.
    always_comb begin
        n_acc  = r_acc;
        n_wp   = r_wp;
        n_farg = r_farg;
        n_pend = r_pend;
        o_wr   = '0;
        o_desc = '0;
        o_rd.valid = i_accept && i_op;
        o_rd.addr  = i_read_addr;
        if (i_accept && i_op) begin
            o_desc.valid = 1'b1;
            o_desc.kind  = KIND_READ;
        end else if (bad) begin
            o_desc.valid = 1'b1;
            o_desc.kind  = KIND_ERROR;
        end else if (char_evt) begin
            case (r_state)
                PS_INITIAL: begin
                    case (cls)
                        CL_AT:    n_pend = CMD_POINTER;
                        CL_L:     n_pend = CMD_LIST;
                        CL_X:     n_pend = CMD_EXECUTE;
                        CL_DIGIT: n_acc  = acc_sh;
                        default:  n_pend = r_pend;
                    endcase
                end
                PS_INSERT: begin
                    if (cls == CL_DIGIT) begin
                        n_acc = acc_sh;
                    end else begin
                        // Space or newline stores the low byte and moves on.
                        o_wr.valid = 1'b1;
                        o_wr.addr  = r_wp;
                        o_wr.data  = r_acc[BYTE_W-1:0];
                        n_acc      = '0;
                        n_wp       = r_wp + ADDR_W'(1);
                    end
                end
                PS_READ_OP: begin
                    if (cls == CL_DIGIT) n_acc = acc_sh;
                    else n_acc = '0;
                end
                PS_ADDRESS: begin
                    case (cls)
                        CL_DIGIT: n_acc = acc_sh;
                        CL_SPACE: begin
                            n_farg = r_acc;
                            n_acc  = '0;
                        end
                        default: begin
                            // Newline runs the pending command.
                            case (r_pend)
                                CMD_POINTER: n_wp = r_acc;
                                CMD_LIST: begin
                                    o_desc.valid  = 1'b1;
                                    o_desc.kind   = KIND_LIST;
                                    o_desc.start  = r_farg;
                                    o_desc.target = r_acc;
                                end
                                CMD_EXECUTE: begin
                                    o_desc.valid  = 1'b1;
                                    o_desc.kind   = KIND_EXEC;
                                    o_desc.target = r_acc;
                                end
                                default: n_wp = r_wp;
                            endcase
                            n_acc = '0;
                        end
                    endcase
                end
                default: n_acc = r_acc;
            endcase
        end
    end

    // State registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= PS_INITIAL;
            r_acc   <= '0;
            r_wp    <= '0;
            r_farg  <= '0;
            r_pend  <= CMD_NONE;
        end else begin
            r_state <= n_state;
            r_acc   <= n_acc;
            r_wp    <= n_wp;
            r_farg  <= n_farg;
            r_pend  <= n_pend;
        end
    end

endmodule

// ===== hdl/hmcp_store.sv =====
// Byte store with address reduction, clearing pass after reset and registered read.
module hmcp_store
    import hmcp_pkg::*;
#(
    parameter int MEM_DEPTH = 4096
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  t_wr_req           i_wr,
    input  t_rd_req           i_rd,
    input  logic              i_rd_adv,
    output logic              o_busy,
    output logic [BYTE_W-1:0] o_rdata
);

    localparam int AW          = $clog2(MEM_DEPTH);
    localparam int SPAN        = 2 ** ADDR_W;
    localparam int RECIP_SHIFT = ADDR_W + 16;
    localparam int RECIP_W     = RECIP_SHIFT - 3;
    localparam int PROD_W      = ADDR_W + RECIP_W;
    localparam int DEPTH_W     = 17;
    localparam int MULT_W      = QUOT_W + DEPTH_W;
    localparam logic [RECIP_W-1:0] RECIP_C =
        RECIP_W'((2 ** RECIP_SHIFT + MEM_DEPTH - 1) / MEM_DEPTH);
    localparam logic [DEPTH_W-1:0] DEPTH_C = DEPTH_W'(MEM_DEPTH);
    localparam logic [AW-1:0]      LAST_C  = AW'(MEM_DEPTH - 1);

    logic [BYTE_W-1:0] mem [MEM_DEPTH];

    logic              r_busy;
    logic [AW-1:0]     r_clr_addr;
    logic              r_wr_valid;
    logic [ADDR_W-1:0] r_wr_addr;
    logic [QUOT_W-1:0] r_wr_q;
    logic [BYTE_W-1:0] r_wr_data;
    logic [ADDR_W-1:0] r_rd_addr;
    logic [QUOT_W-1:0] r_rd_q;
    logic [BYTE_W-1:0] r_rdata;
    logic [AW-1:0]     wr_idx;
    logic [AW-1:0]     rd_idx;

    // Quotient of an address by the depth through a reciprocal multiply.
    function automatic logic [QUOT_W-1:0] f_quot(input logic [ADDR_W-1:0] a);
        logic [PROD_W-1:0] prod;
        prod = PROD_W'(a) * PROD_W'(RECIP_C);
        return prod[RECIP_SHIFT +: QUOT_W];
    endfunction

    // Remainder from the registered quotient; wide stores use the address as is.
    function automatic logic [AW-1:0] f_index(input logic [ADDR_W-1:0] a,
                                              input logic [QUOT_W-1:0] q);
        logic [MULT_W-1:0] prod;
        logic [ADDR_W-1:0] rem;
        prod = MULT_W'(q) * MULT_W'(DEPTH_C);
        rem  = a - prod[ADDR_W-1:0];
        if (MEM_DEPTH >= SPAN) return AW'(a);
        else return AW'(rem);
    endfunction

    assign wr_idx  = f_index(r_wr_addr, r_wr_q);
    assign rd_idx  = f_index(r_rd_addr, r_rd_q);
    assign o_busy  = r_busy;
    assign o_rdata = r_rdata;

    // Clearing pass over every entry after reset.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy     <= 1'b1;
            r_clr_addr <= '0;
        end else if (r_busy) begin
            r_clr_addr <= r_clr_addr + AW'(1);
            if (r_clr_addr == LAST_C) r_busy <= 1'b0;
        end
    end

    // Write request stage; it always drains in the following cycle.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_valid <= 1'b0;
        end else begin
            r_wr_valid <= i_wr.valid;
        end
    end

    // Request payloads with their quotients.
    always_ff @(posedge i_clk) begin
        if (i_wr.valid) begin
            r_wr_addr <= i_wr.addr;
            r_wr_q    <= f_quot(i_wr.addr);
            r_wr_data <= i_wr.data;
        end
        if (i_rd.valid) begin
            r_rd_addr <= i_rd.addr;
            r_rd_q    <= f_quot(i_rd.addr);
        end
    end

    // Memory: one write port shared with the clearing pass, one registered read.
    always_ff @(posedge i_clk) begin
        if (r_busy) begin
            mem[r_clr_addr] <= '0;
        end else if (r_wr_valid) begin
            mem[wr_idx] <= r_wr_data;
        end
        if (i_rd_adv) begin
            r_rdata <= mem[rd_idx];
        end
    end

endmodule

// ===== hdl/hmcp_out.sv =====
// Result stage and output register, with the halted word that follows an error.
module hmcp_out
    import hmcp_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  t_desc             i_desc,
    input  logic [BYTE_W-1:0] i_rdata,
    input  logic              i_stall,
    output t_flow             o_flow,
    output logic              o_valid,
    output logic [2:0]        o_kind,
    output logic [ADDR_W-1:0] o_range_start,
    output logic [ADDR_W-1:0] o_target_addr,
    output logic [BYTE_W-1:0] o_read_byte,
    output logic              o_last
);

    logic              r_s1_valid;
    t_desc             r_s1;
    logic              r_o_valid, n_o_valid;
    t_kind             r_o_kind, n_o_kind;
    logic [ADDR_W-1:0] r_o_start, n_o_start;
    logic [ADDR_W-1:0] r_o_target, n_o_target;
    logic              r_o_last, n_o_last;
    logic              r_pend_halt, n_pend_halt;
    logic              out_free;
    logic              s1_adv;
    logic              s1_ready;

    // Handshake between the result stage and the output register.
    assign out_free = !r_o_valid || !i_stall;
    assign s1_adv   = r_s1_valid && out_free && !r_pend_halt;
    assign s1_ready = !r_s1_valid || s1_adv;

    assign o_flow.s1_ready = s1_ready;
    assign o_flow.s1_adv   = s1_adv;

    // Next output word: the halted word first, then the result stage.
    always_comb begin
        n_o_valid   = r_o_valid;
        n_o_kind    = r_o_kind;
        n_o_start   = r_o_start;
        n_o_target  = r_o_target;
        n_o_last    = r_o_last;
        n_pend_halt = r_pend_halt;
        if (out_free) begin
            if (r_pend_halt) begin
                n_o_valid   = 1'b1;
                n_o_kind    = KIND_HALTED;
                n_o_start   = '0;
                n_o_target  = '0;
                n_o_last    = 1'b1;
                n_pend_halt = 1'b0;
            end else if (r_s1_valid) begin
                n_o_valid   = 1'b1;
                n_o_kind    = r_s1.kind;
                n_o_start   = r_s1.start;
                n_o_target  = r_s1.target;
                n_o_last    = (r_s1.kind != KIND_ERROR);
                n_pend_halt = (r_s1.kind == KIND_ERROR);
            end else begin
                n_o_valid = 1'b0;
            end
        end
    end

    // Control registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid  <= 1'b0;
            r_o_valid   <= 1'b0;
            r_pend_halt <= 1'b0;
        end else begin
            if (s1_ready) r_s1_valid <= i_desc.valid;
            r_o_valid   <= n_o_valid;
            r_pend_halt <= n_pend_halt;
        end
    end

    // Payload registers.
    always_ff @(posedge i_clk) begin
        if (s1_ready) r_s1 <= i_desc;
        r_o_kind   <= n_o_kind;
        r_o_start  <= n_o_start;
        r_o_target <= n_o_target;
        r_o_last   <= n_o_last;
    end

    assign o_valid       = r_o_valid;
    assign o_kind        = r_o_kind;
    assign o_range_start = r_o_start;
    assign o_target_addr = r_o_target;
    assign o_last        = r_o_last;
    assign o_read_byte   = (r_o_kind == KIND_READ) ? i_rdata : '0;

endmodule

// ===== hdl/hmcp_checker.sv =====
// Port-level checker for the hex monitor parser and its bind to the top level.
`include "assert_macros.svh"

module hmcp_checker
    import hmcp_pkg::*;
(
    input logic              i_clk,
    input logic              i_rst_n,
    input logic              i_stall,
    input logic              o_valid,
    input logic [2:0]        o_kind,
    input logic [ADDR_W-1:0] o_range_start,
    input logic [ADDR_W-1:0] o_target_addr,
    input logic [BYTE_W-1:0] o_read_byte,
    input logic              o_last
);

    // A stalled output word holds.
    `ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, o_valid && i_stall, o_valid && $stable(o_kind) && $stable(o_target_addr) && $stable(o_read_byte))

    // An error word that is taken is followed at once by the final halted word.
    `ASSERT_NEXT(a_halt_follows, i_clk, i_rst_n, o_valid && !i_stall && (o_kind == KIND_ERROR), o_valid && (o_kind == KIND_HALTED) && o_last)

    // The error word is never the final word of its input.
    `ASSERT_SAME(a_error_not_last, i_clk, i_rst_n, o_valid && (o_kind == KIND_ERROR), !o_last)

    // Only list words carry a start address.
    `ASSERT_SAME(a_start_list_only, i_clk, i_rst_n, o_valid && (o_kind != KIND_LIST), o_range_start == '0)

    // Only read words carry a data byte.
    `ASSERT_SAME(a_byte_read_only, i_clk, i_rst_n, o_valid && (o_kind != KIND_READ), o_read_byte == '0)

endmodule

bind hex_monitor_command_parser_unit hmcp_checker u_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .i_stall       (i_stall),
    .o_valid       (o_valid),
    .o_kind        (o_kind),
    .o_range_start (o_range_start),
    .o_target_addr (o_target_addr),
    .o_read_byte   (o_read_byte),
    .o_last        (o_last)
);
